// ----- hdl/clc_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular list cursor engine package
// Shared codes, command and status types for the controller and datapath.
// ----------------------------------------------------------------------------
package clc_pkg;

  localparam int ModeWidth   = 3;
  localparam int ValueWidth  = 32;
  localparam int PosWidth    = 6;
  localparam int CountWidth  = 7;
  localparam int StatusWidth = 2;
  localparam int InDataWidth  = 48;
  localparam int OutDataWidth = 48;

  localparam logic [ModeWidth-1:0] MODE_APPEND  = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_FORWARD = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_BACK    = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_DEL_CUR = 3'd3;
  localparam logic [ModeWidth-1:0] MODE_DEL_POS = 3'd4;

  localparam logic [StatusWidth-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_WALK_INIT,
    OP_WALK_STEP,
    OP_ALLOC,
    OP_LINK_TAIL,
    OP_LINK_HEAD,
    OP_FWD,
    OP_BWD,
    OP_UNLINK,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic                   set_status;
    logic [StatusWidth-1:0] status_code;
    logic                   in_ready;
  } cmd_t;

  typedef struct packed {
    logic                 in_valid;
    logic [ModeWidth-1:0] mode;
    logic                 list_empty;
    logic                 list_full;
    logic                 walk_done;
    logic                 out_busy;
  } stat_t;

endpackage

// ----- hdl/clc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/clc_dpath.sv -----
// ----------------------------------------------------------------------------
// Circular list datapath
// Link, value and free-slot memories with the list pointers and result register.
// ----------------------------------------------------------------------------
module clc_dpath #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  clc_pkg::cmd_t                      cmd_i,
  output clc_pkg::stat_t                     stat_o,
  input  logic                               in_valid_i,
  input  logic [clc_pkg::ModeWidth-1:0]      in_mode_i,
  input  logic [clc_pkg::ValueWidth-1:0]     in_value_i,
  input  logic [clc_pkg::PosWidth-1:0]       in_position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [clc_pkg::PosWidth-1:0]       out_position_o,
  output logic [clc_pkg::ValueWidth-1:0]     out_value_o,
  output logic [clc_pkg::CountWidth-1:0]     out_count_o,
  output logic [clc_pkg::StatusWidth-1:0]    out_status_o
);
  import clc_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [SW-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d, idx_q, idx_d;
  logic [CW-1:0] count_q, count_d, fill_q, fill_d, sp_q, sp_d;
  logic [StatusWidth-1:0] status_q, status_d;
  logic out_valid_q, out_valid_d;

  logic [ModeWidth-1:0]      mode_q;
  logic [VALUE_WIDTH-1:0]    val_q;
  logic [PosWidth-1:0]       rem_q;
  logic [SW-1:0]             tgt_q, tgt_idx_q, new_q;
  logic [PosWidth-1:0]       opos_q;
  logic [ValueWidth-1:0]     oval_q;
  logic [CountWidth-1:0]     ocnt_q;
  logic [StatusWidth-1:0]    ostat_q;

  logic [SW-1:0] next_rdata, prev_rdata, stack_rdata, alloc_slot;
  logic [VALUE_WIDTH-1:0] value_rdata;
  logic next_we, prev_we, value_we, stack_we;
  logic [SW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic signed [ValueWidth-1:0] in_sval;
  logic signed [VALUE_WIDTH-1:0] rd_sval;

  assign in_sval    = in_value_i;
  assign rd_sval    = value_rdata;
  assign alloc_slot = (sp_q != '0) ? stack_rdata : fill_q[SW-1:0];

  clc_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next (
    .clk_i(clk_i), .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .raddr_i(tgt_q), .rdata_o(next_rdata)
  );

  clc_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev (
    .clk_i(clk_i), .we_i(prev_we), .waddr_i(prev_waddr), .wdata_i(prev_wdata),
    .raddr_i(tgt_q), .rdata_o(prev_rdata)
  );

  clc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_value (
    .clk_i(clk_i), .we_i(value_we), .waddr_i(new_q), .wdata_i(val_q),
    .raddr_i(cur_q), .rdata_o(value_rdata)
  );

  // Freed slots are stacked here; fresh slots come from the fill counter.
  clc_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_stack (
    .clk_i(clk_i), .we_i(stack_we), .waddr_i(sp_q[SW-1:0]), .wdata_i(tgt_q),
    .raddr_i(SW'(sp_q - CW'(1))), .rdata_o(stack_rdata)
  );

  always_comb begin
    next_we    = 1'b0;
    prev_we    = 1'b0;
    value_we   = 1'b0;
    stack_we   = 1'b0;
    next_waddr = tail_q;
    next_wdata = new_q;
    prev_waddr = new_q;
    prev_wdata = tail_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    count_d    = count_q;
    fill_d     = fill_q;
    sp_d       = sp_q;
    status_d   = cmd_i.set_status ? cmd_i.status_code : status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cmd_i.op)
      OP_ALLOC: begin
        if (sp_q != '0) begin
          sp_d = sp_q - CW'(1);
        end else begin
          fill_d = fill_q + CW'(1);
        end
        if (count_q == '0) begin
          head_d = alloc_slot;
          tail_d = alloc_slot;
          cur_d  = alloc_slot;
          idx_d  = '0;
        end
      end
      OP_LINK_TAIL: begin
        next_we  = 1'b1;
        prev_we  = 1'b1;
        value_we = 1'b1;
      end
      OP_LINK_HEAD: begin
        next_we    = 1'b1;
        next_waddr = new_q;
        next_wdata = head_q;
        prev_we    = 1'b1;
        prev_waddr = head_q;
        prev_wdata = new_q;
        tail_d     = new_q;
        count_d    = count_q + CW'(1);
      end
      OP_FWD: begin
        idx_d = (cur_q == tail_q) ? '0 : idx_q + SW'(1);
        cur_d = next_rdata;
      end
      OP_BWD: begin
        idx_d = (cur_q == head_q) ? SW'(count_q - CW'(1)) : idx_q - SW'(1);
        cur_d = prev_rdata;
      end
      OP_UNLINK: begin
        stack_we = 1'b1;
        sp_d     = sp_q + CW'(1);
        if (count_q == CW'(1)) begin
          head_d  = '0;
          tail_d  = '0;
          cur_d   = '0;
          idx_d   = '0;
          count_d = '0;
        end else begin
          next_we    = 1'b1;
          next_waddr = prev_rdata;
          next_wdata = next_rdata;
          prev_we    = 1'b1;
          prev_waddr = next_rdata;
          prev_wdata = prev_rdata;
          if (tgt_q == tail_q) begin
            tail_d = prev_rdata;
            idx_d  = '0;
          end else begin
            idx_d = tgt_idx_q;
          end
          if (tgt_q == head_q) begin
            head_d = next_rdata;
          end
          cur_d   = next_rdata;
          count_d = count_q - CW'(1);
        end
      end
      OP_RESULT: begin
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cur_q       <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      fill_q      <= '0;
      sp_q        <= '0;
      status_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      sp_q        <= sp_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item registers and the walk pointer; the link memories read at tgt_q.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q    <= in_mode_i;
        val_q     <= VALUE_WIDTH'(in_sval);
        rem_q     <= in_position_i;
        tgt_q     <= cur_q;
        tgt_idx_q <= idx_q;
      end
      OP_WALK_INIT: begin
        tgt_q     <= head_q;
        tgt_idx_q <= '0;
      end
      OP_WALK_STEP: begin
        tgt_q     <= next_rdata;
        tgt_idx_q <= (tgt_q == tail_q) ? '0 : tgt_idx_q + SW'(1);
        rem_q     <= rem_q - PosWidth'(1);
      end
      OP_ALLOC: begin
        new_q <= alloc_slot;
      end
      OP_RESULT: begin
        opos_q  <= (count_q == '0) ? '0 : PosWidth'(idx_q);
        oval_q  <= (count_q == '0) ? '0 : ValueWidth'(rd_sval);
        ocnt_q  <= CountWidth'(count_q);
        ostat_q <= status_q;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.in_valid   = in_valid_i;
  assign stat_o.mode       = mode_q;
  assign stat_o.list_empty = (count_q == '0);
  assign stat_o.list_full  = (count_q == CW'(CAPACITY));
  assign stat_o.walk_done  = (rem_q == '0);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_position_o = opos_q;
  assign out_value_o    = oval_q;
  assign out_count_o    = ocnt_q;
  assign out_status_o   = ostat_q;

endmodule

// ----- hdl/clc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Circular list controller
// Sequences each item through the datapath as a series of commands, one item at a time.
// ----------------------------------------------------------------------------
module clc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clc_pkg::stat_t stat_i,
  output clc_pkg::cmd_t  cmd_o
);
  import clc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_LINK_TAIL,
    S_LINK_HEAD,
    S_MOVE,
    S_WALK_CHK,
    S_WALK_STEP,
    S_UNLINK,
    S_VAL_WAIT,
    S_RESULT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d           = state_q;
    cmd_o.op          = OP_IDLE;
    cmd_o.set_status  = 1'b0;
    cmd_o.status_code = STATUS_OK;
    cmd_o.in_ready    = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.set_status = 1'b1;
        state_d          = S_VAL_WAIT;
        if (stat_i.mode == MODE_APPEND) begin
          if (stat_i.list_full) begin
            cmd_o.status_code = STATUS_FULL;
          end else begin
            state_d = S_ALLOC;
          end
        end else if (stat_i.mode == MODE_FORWARD || stat_i.mode == MODE_BACK ||
                     stat_i.mode == MODE_DEL_CUR || stat_i.mode == MODE_DEL_POS) begin
          if (stat_i.list_empty) begin
            cmd_o.status_code = STATUS_EMPTY;
          end else if (stat_i.mode == MODE_DEL_CUR) begin
            state_d = S_UNLINK;
          end else if (stat_i.mode == MODE_DEL_POS) begin
            cmd_o.op = OP_WALK_INIT;
            state_d  = S_WALK_CHK;
          end else begin
            state_d = S_MOVE;
          end
        end
      end
      S_ALLOC: begin
        cmd_o.op = OP_ALLOC;
        state_d  = S_LINK_TAIL;
      end
      S_LINK_TAIL: begin
        cmd_o.op = OP_LINK_TAIL;
        state_d  = S_LINK_HEAD;
      end
      S_LINK_HEAD: begin
        cmd_o.op = OP_LINK_HEAD;
        state_d  = S_VAL_WAIT;
      end
      S_MOVE: begin
        cmd_o.op = (stat_i.mode == MODE_FORWARD) ? OP_FWD : OP_BWD;
        state_d  = S_VAL_WAIT;
      end
      // Each step waits in S_WALK_CHK for the link read at the new slot.
      S_WALK_CHK: begin
        state_d = stat_i.walk_done ? S_UNLINK : S_WALK_STEP;
      end
      S_WALK_STEP: begin
        cmd_o.op = OP_WALK_STEP;
        state_d  = S_WALK_CHK;
      end
      S_UNLINK: begin
        cmd_o.op = OP_UNLINK;
        state_d  = S_VAL_WAIT;
      end
      S_VAL_WAIT: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/circular_list_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// Circular list cursor engine
// Bounded circular doubly linked list of signed words with a cursor.
// ----------------------------------------------------------------------------
// Each item on the slave stream carries one command (append, move forward,
// move back, delete at cursor, delete at position) and yields exactly one
// result item on the master stream: cursor index, value at the cursor, entry
// count and status.
// Items are handled one at a time. Delete at position walks from the head,
// following one link per step through the link memory's registered read
// port. Unused modes, and commands refused because the list is empty or
// full, go straight to the result. The next item can be accepted in the
// cycle after the result is registered.
// The result sits in an output register; a new item is accepted while it
// waits, but the next result is held back until the receiver takes it.
// Reset empties the list at once; the slot memories need no clearing.
// ----------------------------------------------------------------------------
module circular_list_cursor_engine #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // mode [2:0], value [34:3], position [40:35], zero fill above
  input  logic [clc_pkg::InDataWidth-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cursor_position [5:0], cursor_value [37:6], entry_count [44:38],
  // status [46:45], zero fill above
  output logic [clc_pkg::OutDataWidth-1:0]    m_axis_tdata
);
  import clc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [PosWidth-1:0]    out_position;
  logic [ValueWidth-1:0]  out_value;
  logic [CountWidth-1:0]  out_count;
  logic [StatusWidth-1:0] out_status;

  clc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  clc_dpath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_valid_i     (s_axis_tvalid),
    .in_mode_i      (s_axis_tdata[2:0]),
    .in_value_i     (s_axis_tdata[34:3]),
    .in_position_i  (s_axis_tdata[40:35]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_position_o (out_position),
    .out_value_o    (out_value),
    .out_count_o    (out_count),
    .out_status_o   (out_status)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {1'b0, out_status, out_count, out_value, out_position};

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Circular list cursor engine testbench
// Drives list commands on the slave stream, predicts each result with a
// slot-level model of the linked list and compares the master stream with it.
// ----------------------------------------------------------------------------
module tb_top;
  import clc_pkg::*;

  localparam int Cap = 64;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;

  // Highest field first, so that cur_pos lands in the lowest bits.
  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [CountWidth-1:0]  cnt;
    logic [ValueWidth-1:0]  cur_val;
    logic [PosWidth-1:0]    cur_pos;
  } list_result_t;

  circular_list_cursor_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the list.
  logic [ValueWidth-1:0] sh_value [Cap];
  int unsigned           sh_next  [Cap];
  int unsigned           sh_prev  [Cap];
  bit                    sh_free  [Cap];
  int unsigned sh_head, sh_tail, sh_cur, sh_idx, sh_count;

  list_result_t expected_results[$];
  int errors;
  int results_seen;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic list_reset();
    for (int i = 0; i < Cap; i++) sh_free[i] = 1'b1;
    sh_head = 0; sh_tail = 0; sh_cur = 0; sh_idx = 0; sh_count = 0;
  endtask

  function automatic void unlink_slot(int unsigned s, int unsigned idx);
    int unsigned nx, pv;
    nx = sh_next[s];
    pv = sh_prev[s];
    sh_free[s] = 1'b1;
    if (sh_count <= 1) begin
      sh_count = 0; sh_head = 0; sh_tail = 0; sh_cur = 0; sh_idx = 0;
      return;
    end
    if (s == sh_tail) begin
      sh_tail = pv;
      idx = 0;
    end
    if (s == sh_head) sh_head = nx;
    sh_next[pv] = nx;
    sh_prev[nx] = pv;
    sh_cur = nx;
    sh_idx = idx;
    sh_count--;
  endfunction

  function automatic list_result_t predict_list_step(logic [ModeWidth-1:0] mode,
                                                     logic [ValueWidth-1:0] val,
                                                     logic [PosWidth-1:0] pos);
    list_result_t r;
    int unsigned s, steps;
    r = '0;
    r.status = STATUS_OK;
    if (mode == MODE_APPEND) begin
      if (sh_count >= Cap) r.status = STATUS_FULL;
      else begin
        s = 0;
        while (!sh_free[s]) s++;
        sh_free[s] = 1'b0;
        sh_value[s] = val;
        if (sh_count == 0) begin
          sh_head = s; sh_tail = s; sh_next[s] = s; sh_prev[s] = s;
          sh_cur = s; sh_idx = 0;
        end else begin
          sh_next[sh_tail] = s; sh_prev[s] = sh_tail;
          sh_next[s] = sh_head; sh_prev[sh_head] = s;
          sh_tail = s;
        end
        sh_count++;
      end
    end else if (mode inside {MODE_FORWARD, MODE_BACK, MODE_DEL_CUR, MODE_DEL_POS}) begin
      if (sh_count == 0) r.status = STATUS_EMPTY;
      else if (mode == MODE_FORWARD) begin
        sh_idx = (sh_cur == sh_tail) ? 0 : sh_idx + 1;
        sh_cur = sh_next[sh_cur];
      end else if (mode == MODE_BACK) begin
        sh_idx = (sh_cur == sh_head) ? sh_count - 1 : sh_idx - 1;
        sh_cur = sh_prev[sh_cur];
      end else if (mode == MODE_DEL_CUR) begin
        unlink_slot(sh_cur, sh_idx);
      end else begin
        steps = pos % sh_count;
        s = sh_head;
        for (int i = 0; i < steps; i++) s = sh_next[s];
        unlink_slot(s, steps);
      end
    end
    if (sh_count != 0) begin
      r.cur_pos = sh_idx[PosWidth-1:0];
      r.cur_val = sh_value[sh_cur];
    end
    r.cnt = sh_count[CountWidth-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    $display("mismatch on result %0d: %s got %0d expected %0d",
             results_seen, field, got, want);
  endtask

  // Sends one item, holding tvalid across back-to-back items.
  task automatic send_command(logic [ModeWidth-1:0] mode, logic [ValueWidth-1:0] val,
                              logic [PosWidth-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, pos, val, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(predict_list_step(mode, val, pos));
  endtask

  task automatic go_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    list_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[46:0];
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("unexpected result %0d", results_seen);
      end else begin
        want = expected_results.pop_front();
        if (got.cur_pos != want.cur_pos) report_mismatch("cursor_position", got.cur_pos, want.cur_pos);
        if (got.cur_val != want.cur_val) report_mismatch("cursor_value", got.cur_val, want.cur_val);
        if (got.cnt != want.cnt) report_mismatch("entry_count", got.cnt, want.cnt);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (m_axis_tdata[47] !== 1'b0) report_mismatch("zero fill", m_axis_tdata[47], 0);
      end
    end
  end

  task automatic test_directed();
    // Empty-list moves and deletes, and an unused mode.
    send_command(MODE_FORWARD, 0, 0);
    send_command(MODE_BACK, 0, 0);
    send_command(MODE_DEL_CUR, 0, 0);
    send_command(MODE_DEL_POS, 0, 63);
    send_command(3'd7, 32'hFFFF_FFFF, 6'h3F);
    send_command(MODE_APPEND, 32'h8000_0000, 0);
    send_command(MODE_DEL_CUR, 0, 0);      // deletes the last entry
    send_command(MODE_APPEND, 32'h7FFF_FFFF, 0);
    send_command(MODE_APPEND, 32'hFFFF_FFFF, 0);
    send_command(MODE_APPEND, 32'h0, 0);
    send_command(MODE_BACK, 0, 0);         // wrap from head to tail
    send_command(MODE_FORWARD, 0, 0);      // wrap from tail to head
    send_command(MODE_BACK, 0, 0);
    send_command(MODE_DEL_CUR, 0, 0);      // tail removed, cursor to head
    send_command(MODE_DEL_POS, 0, 63);     // position wraps
    send_command(3'd5, 0, 0);
    send_command(3'd6, 0, 0);
    send_command(MODE_DEL_POS, 0, 0);
  endtask

  task automatic test_fill_and_pressure();
    // Fill to capacity with the receiver held off, then append when full.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < Cap + 2; i++) send_command(MODE_APPEND, $urandom, 0);
        send_command(MODE_DEL_POS, 0, 6'd63);
        send_command(MODE_APPEND, $urandom, 0);
      end
    join
  endtask

  task automatic test_random(int n);
    logic [ModeWidth-1:0] mode;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) mode = MODE_APPEND;
      else if (pick < 55) mode = MODE_FORWARD;
      else if (pick < 70) mode = MODE_BACK;
      else if (pick < 82) mode = MODE_DEL_CUR;
      else if (pick < 97) mode = MODE_DEL_POS;
      else mode = 3'($urandom_range(7, 5));
      // Mostly short walks; every so often a long one.
      send_command(mode, $urandom,
                   ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(7)));
    end
  endtask

  task automatic drain();
    int guard;
    go_quiet();
    guard = 0;
    while (expected_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    hold_off = 1'b0;
    send_idle_pct = 10;
    recv_stall_pct = 63;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    list_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_and_pressure();
    test_random(600);
    send_idle_pct = 63;
    recv_stall_pct = 10;
    test_random(600);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(500);
    drain();

    $display("Covered %0d results: appends to full, moves with wrap, deletes at cursor",
             results_seen);
    $display("and position, empty-list commands, unused modes and a long output stall.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
